[hw/rtl/ate_pkg.sv]
package ate_pkg;

  typedef enum logic [3:0] {
    FN_APPEND    = 4'd0,
    FN_INSERT    = 4'd1,
    FN_DELETE    = 4'd2,
    FN_GET       = 4'd3,
    FN_SET       = 4'd4,
    FN_SEARCH    = 4'd5,
    FN_TRANSPOSE = 4'd6,
    FN_TO_HEAD   = 4'd7,
    FN_BSEARCH   = 4'd8,
    FN_MAX       = 4'd9,
    FN_MIN       = 4'd10,
    FN_SUM       = 4'd11
  } func_e;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_RANGE = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_MISS  = 3'd3,
    STAT_EMPTY = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    INIT_NONE,
    INIT_DOWN,
    INIT_IDX_CNT,
    INIT_IDX_IDX,
    INIT_ALL,
    INIT_BS
  } init_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_TAIL,
    WR_IDX,
    WR_SW1,
    WR_SW2
  } wr_e;

  typedef struct packed {
    logic    load;
    init_e   init;
    logic    issue;
    logic    bs_issue;
    wr_e     wr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    finish;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  full;
    logic  idx_gt;
    logic  idx_ge;
    logic  idx_eq;
    logic  empty;
    logic  last;
    logic  hit;
    logic  found;
    logic  pos_zero;
    logic  bs_open;
  } dp_stat_t;

endpackage

[hw/rtl/ate_dp.sv]
module ate_dp #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [4:0]        cfg_wdata_i,
  input  logic [3:0]        in_func_i,
  input  logic [4:0]        in_index_i,
  input  logic [31:0]       in_value_i,
  input  ate_pkg::dp_cmd_t  cmd_i,
  output ate_pkg::dp_stat_t stat_o,
  output logic [2:0]        out_status_o,
  output logic [3:0]        out_position_o,
  output logic [35:0]       out_data_o,
  output logic [4:0]        out_count_o
);
  import ate_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int IW = (AW > 5) ? AW : 5;

  logic [31:0] mem [DEPTH];

  logic [4:0]  cap_q, cnt_q, cnt_d;
  logic        rv_q, found_q, found_d;
  func_e       func_q;
  logic [4:0]  idx_q, ptr_q, end_q, ra_q, pos_q;
  logic        down_q;
  logic [31:0] val_q, rd_q, prev_q, head_q;
  logic [35:0] acc_q;
  logic [5:0]  lo_q, hi_q;

  logic [6:0]    bs_sum;
  logic [4:0]    mid, rd_sel, wa;
  logic [IW-1:0] rd_ext, wr_ext;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_en, we, shift_we, match, is_search, hit, full;
  logic [31:0]   wd;
  logic [35:0]   rd_sx;

  assign bs_sum    = {lo_q[5], lo_q} + {hi_q[5], hi_q};
  assign mid       = bs_sum[5:1];
  assign rd_en     = cmd_i.issue | cmd_i.bs_issue;
  assign rd_sel    = cmd_i.issue ? ptr_q : mid;
  assign rd_ext    = IW'(rd_sel);
  assign rd_addr   = rd_ext[AW-1:0];
  assign rd_sx     = {{4{rd_q[31]}}, rd_q};
  assign match     = (rd_q == val_q);
  assign is_search = (func_q inside {FN_SEARCH, FN_TRANSPOSE, FN_TO_HEAD, FN_BSEARCH});
  assign hit       = rv_q && is_search && !found_q && match;
  assign full      = (cnt_q >= cap_q) || (32'(cnt_q) >= 32'(DEPTH));

  always_comb begin
    shift_we = 1'b0;
    wa       = ra_q;
    wd       = rd_q;
    if (rv_q && func_q == FN_INSERT) begin
      shift_we = 1'b1;
      wa       = ra_q + 5'd1;
    end else if (rv_q && func_q == FN_DELETE && ra_q != idx_q) begin
      shift_we = 1'b1;
      wa       = ra_q - 5'd1;
    end
    we = shift_we;
    case (cmd_i.wr)
      WR_TAIL: begin
        we = 1'b1;
        wa = cnt_q;
        wd = val_q;
      end
      WR_IDX: begin
        we = 1'b1;
        wa = idx_q;
        wd = val_q;
      end
      WR_SW1: begin
        we = 1'b1;
        wa = (func_q == FN_TRANSPOSE) ? pos_q - 5'd1 : 5'd0;
        wd = val_q;
      end
      WR_SW2: begin
        we = 1'b1;
        wa = pos_q;
        wd = (func_q == FN_TRANSPOSE) ? prev_q : head_q;
      end
      default: ;
    endcase
  end

  assign wr_ext  = IW'(wa);
  assign wr_addr = wr_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 5'd1;
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - 5'd1;
    end
    found_d = found_q;
    if (cmd_i.load) begin
      found_d = 1'b0;
    end else if (hit) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= 5'd16;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      cnt_q   <= cnt_d;
      rv_q    <= rd_en;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(in_func_i);
      idx_q  <= in_index_i;
      val_q  <= in_value_i;
      acc_q  <= '0;
    end
    if (rd_en) begin
      ra_q <= rd_sel;
    end
    if (cmd_i.issue) begin
      ptr_q <= down_q ? ptr_q - 5'd1 : ptr_q + 5'd1;
    end
    unique case (cmd_i.init)
      INIT_DOWN: begin
        ptr_q  <= cnt_q - 5'd1;
        end_q  <= idx_q;
        down_q <= 1'b1;
      end
      INIT_IDX_CNT: begin
        ptr_q  <= idx_q;
        end_q  <= cnt_q - 5'd1;
        down_q <= 1'b0;
      end
      INIT_IDX_IDX: begin
        ptr_q  <= idx_q;
        end_q  <= idx_q;
        down_q <= 1'b0;
      end
      INIT_ALL: begin
        ptr_q  <= '0;
        end_q  <= cnt_q - 5'd1;
        down_q <= 1'b0;
      end
      INIT_BS: begin
        lo_q <= '0;
        hi_q <= {1'b0, cnt_q} - 6'd1;
      end
      default: ;
    endcase
    if (rv_q) begin
      case (func_q)
        FN_DELETE, FN_GET: begin
          if (ra_q == idx_q) begin
            acc_q <= rd_sx;
          end
        end
        FN_MAX: begin
          if (ra_q == 5'd0 || $signed(rd_q) > $signed(acc_q[31:0])) begin
            acc_q <= rd_sx;
          end
        end
        FN_MIN: begin
          if (ra_q == 5'd0 || $signed(rd_q) < $signed(acc_q[31:0])) begin
            acc_q <= rd_sx;
          end
        end
        FN_SUM: begin
          acc_q <= (ra_q == 5'd0) ? rd_sx : acc_q + rd_sx;
        end
        FN_SEARCH, FN_TRANSPOSE, FN_TO_HEAD: begin
          if (ra_q == 5'd0) begin
            head_q <= rd_q;
          end
          if (!found_q) begin
            if (match) begin
              pos_q <= ra_q;
            end else begin
              prev_q <= rd_q;
            end
          end
        end
        FN_BSEARCH: begin
          if (match) begin
            pos_q <= ra_q;
          end else if ($signed(val_q) < $signed(rd_q)) begin
            hi_q <= {1'b0, ra_q} - 6'd1;
          end else begin
            lo_q <= {1'b0, ra_q} + 6'd1;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      out_status_o   <= cmd_i.code;
      out_position_o <= (cmd_i.code == STAT_OK && found_q) ? pos_q[3:0] : 4'd0;
      out_data_o     <= (cmd_i.code == STAT_OK &&
                         (func_q inside {FN_DELETE, FN_GET, FN_MAX, FN_MIN, FN_SUM}))
                        ? acc_q : 36'd0;
      out_count_o    <= cnt_q;
    end
  end

  always_comb begin
    stat_o.func     = func_q;
    stat_o.full     = full;
    stat_o.idx_gt   = idx_q > cnt_q;
    stat_o.idx_ge   = idx_q >= cnt_q;
    stat_o.idx_eq   = idx_q == cnt_q;
    stat_o.empty    = cnt_q == 5'd0;
    stat_o.last     = ptr_q == end_q;
    stat_o.hit      = hit;
    stat_o.found    = found_q;
    stat_o.pos_zero = pos_q == 5'd0;
    stat_o.bs_open  = $signed(lo_q) <= $signed(hi_q);
  end

  a_cnt_one_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.cnt_inc && cmd_i.cnt_dec))
    else $error("fill count moved both ways");

  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_we |-> cmd_i.wr == WR_NONE)
    else $error("shift write collides with command write");

  a_hit_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit && !cmd_i.load |=> found_q)
    else $error("hit not recorded");

  a_grow_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> !full)
    else $error("growth past capacity");

endmodule

[hw/rtl/ate_ctrl.sv]
module ate_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ate_pkg::dp_stat_t stat_i,
  output ate_pkg::dp_cmd_t  cmd_o
);
  import ate_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN,
    ST_POST,
    ST_BS_RD,
    ST_BS_CMP,
    ST_INS_WR,
    ST_SWAP1,
    ST_SWAP2,
    ST_FINISH
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;
  logic    out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    code_d  = code_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        code_d  = STAT_OK;
        state_d = ST_FINISH;
        unique case (stat_i.func)
          FN_APPEND: begin
            if (stat_i.full) begin
              code_d = STAT_FULL;
            end else begin
              cmd_o.wr      = WR_TAIL;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          FN_INSERT: begin
            if (stat_i.idx_gt) begin
              code_d = STAT_RANGE;
            end else if (stat_i.full) begin
              code_d = STAT_FULL;
            end else if (stat_i.idx_eq) begin
              cmd_o.wr      = WR_IDX;
              cmd_o.cnt_inc = 1'b1;
            end else begin
              cmd_o.init = INIT_DOWN;
              state_d    = ST_WALK;
            end
          end
          FN_DELETE: begin
            if (stat_i.idx_ge) begin
              code_d = STAT_RANGE;
            end else begin
              cmd_o.init = INIT_IDX_CNT;
              state_d    = ST_WALK;
            end
          end
          FN_GET: begin
            if (stat_i.idx_ge) begin
              code_d = STAT_RANGE;
            end else begin
              cmd_o.init = INIT_IDX_IDX;
              state_d    = ST_WALK;
            end
          end
          FN_SET: begin
            if (stat_i.idx_ge) begin
              code_d = STAT_RANGE;
            end else begin
              cmd_o.wr = WR_IDX;
            end
          end
          FN_SEARCH, FN_TRANSPOSE, FN_TO_HEAD: begin
            if (stat_i.empty) begin
              code_d = STAT_MISS;
            end else begin
              cmd_o.init = INIT_ALL;
              state_d    = ST_WALK;
            end
          end
          FN_BSEARCH: begin
            if (stat_i.empty) begin
              code_d = STAT_MISS;
            end else begin
              cmd_o.init = INIT_BS;
              state_d    = ST_BS_RD;
            end
          end
          FN_MAX, FN_MIN: begin
            if (stat_i.empty) begin
              code_d = STAT_EMPTY;
            end else begin
              cmd_o.init = INIT_ALL;
              state_d    = ST_WALK;
            end
          end
          FN_SUM: begin
            if (!stat_i.empty) begin
              cmd_o.init = INIT_ALL;
              state_d    = ST_WALK;
            end
          end
          default: ;
        endcase
      end
      ST_WALK: begin
        if (stat_i.hit) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
          if (stat_i.last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_d = ST_POST;
      end
      ST_POST: begin
        state_d = ST_FINISH;
        case (stat_i.func)
          FN_DELETE: cmd_o.cnt_dec = 1'b1;
          FN_INSERT: state_d = ST_INS_WR;
          FN_SEARCH, FN_TRANSPOSE, FN_TO_HEAD: begin
            if (!stat_i.found) begin
              code_d = STAT_MISS;
            end else if ((stat_i.func == FN_TRANSPOSE && !stat_i.pos_zero) ||
                         stat_i.func == FN_TO_HEAD) begin
              state_d = ST_SWAP1;
            end
          end
          default: ;
        endcase
      end
      ST_BS_RD: begin
        if (!stat_i.bs_open) begin
          code_d  = STAT_MISS;
          state_d = ST_FINISH;
        end else begin
          cmd_o.bs_issue = 1'b1;
          state_d        = ST_BS_CMP;
        end
      end
      ST_BS_CMP: begin
        state_d = stat_i.hit ? ST_FINISH : ST_BS_RD;
      end
      ST_INS_WR: begin
        cmd_o.wr      = WR_IDX;
        cmd_o.cnt_inc = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_SWAP1: begin
        cmd_o.wr = WR_SW1;
        state_d  = ST_SWAP2;
      end
      ST_SWAP2: begin
        cmd_o.wr = WR_SW2;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.code = code_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      code_q      <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_fin_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_CHECK)
    else $error("request not checked after load");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && stat_i.last && !stat_i.hit) |=> state_q == ST_DRAIN)
    else $error("walk ran past its end");

endmodule

[hw/rtl/array_table_engine.sv]
// Append, set and rejected requests go from the check straight to the result.
// Walks read one entry per cycle, and a search walk stops once it hits; insert adds the
// write of the new value after its walk, and a transpose or move-to-head adds a swap.
// Binary search alternates a read and a compare for each probe until a hit or a miss.
// One request in work at a time; the next is taken only once the last result is registered.
// Reset clears the fill count and restores capacity to 16; entries are not cleared.
module array_table_engine #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // index[4:0], value[36:5], zero[39:37]
  input  logic [3:0]  s_axis_tuser,  // func[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // position[3:0], data[39:4], count[44:40], zero[47:45]
  output logic [2:0]  m_axis_tuser   // status[2:0]
);
  import ate_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [3:0]  position;
  logic [35:0] data;
  logic [4:0]  count;

  ate_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ate_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_func_i      (s_axis_tuser),
    .in_index_i     (s_axis_tdata[4:0]),
    .in_value_i     (s_axis_tdata[36:5]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_status_o   (m_axis_tuser),
    .out_position_o (position),
    .out_data_o     (data),
    .out_count_o    (count)
  );

  assign m_axis_tdata = {3'b000, count, data, position};

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import ate_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int RANDOM_ITEMS = 1100;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [3:0]  func;
    logic [4:0]  index;
    logic [31:0] value;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  position;
    logic [35:0] data;
    logic [4:0]  count;
  } reply_t;

  typedef struct {
    request_t req;
    logic     fixed;
    reply_t   rsp;
  } vector_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  array_table_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  logic [31:0] shadow_words [NUM_SLOTS];
  logic [4:0]  shadow_fill;
  logic [4:0]  shadow_cap;
  reply_t      pending_replies [$];
  int          error_count = 0;
  int          quiet_cycles = 0;
  bit          hold_off = 1'b0;
  bit          walking = 1'b0;
  vector_t     vectors [$];

  function automatic logic [4:0] room_limit();
    return (shadow_cap < NUM_SLOTS) ? shadow_cap : 5'(NUM_SLOTS);
  endfunction

  function automatic bit find_key(input logic [31:0] key, output logic [3:0] pos);
    pos = '0;
    for (int i = 0; i < shadow_fill; i++) begin
      if (shadow_words[i] == key) begin
        pos = 4'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic reply_t predict_reply(input request_t rq);
    reply_t      r;
    logic [31:0] t;
    logic [3:0]  p;
    int          lo;
    int          hi;
    int          mid;
    logic signed [31:0] best;
    r.status = STAT_OK;
    r.position = '0;
    r.data = '0;
    case (rq.func)
      FN_APPEND: begin
        if (shadow_fill >= room_limit()) r.status = STAT_FULL;
        else begin
          shadow_words[shadow_fill] = rq.value;
          shadow_fill++;
        end
      end
      FN_INSERT: begin
        if (rq.index > shadow_fill) r.status = STAT_RANGE;
        else if (shadow_fill >= room_limit()) r.status = STAT_FULL;
        else begin
          for (int i = shadow_fill; i > rq.index; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[rq.index] = rq.value;
          shadow_fill++;
        end
      end
      FN_DELETE: begin
        if (rq.index >= shadow_fill) r.status = STAT_RANGE;
        else begin
          r.data = 36'(signed'(shadow_words[rq.index]));
          for (int i = rq.index; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i+1];
          shadow_fill--;
        end
      end
      FN_GET: begin
        if (rq.index >= shadow_fill) r.status = STAT_RANGE;
        else r.data = 36'(signed'(shadow_words[rq.index]));
      end
      FN_SET: begin
        if (rq.index >= shadow_fill) r.status = STAT_RANGE;
        else shadow_words[rq.index] = rq.value;
      end
      FN_SEARCH, FN_TRANSPOSE, FN_TO_HEAD: begin
        if (!find_key(rq.value, p)) r.status = STAT_MISS;
        else begin
          r.position = p;
          if (rq.func == FN_TRANSPOSE && p > 0) begin
            t = shadow_words[p];
            shadow_words[p] = shadow_words[p-1];
            shadow_words[p-1] = t;
          end else if (rq.func == FN_TO_HEAD) begin
            t = shadow_words[p];
            shadow_words[p] = shadow_words[0];
            shadow_words[0] = t;
          end
        end
      end
      FN_BSEARCH: begin
        lo = 0;
        hi = int'(shadow_fill) - 1;
        r.status = STAT_MISS;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (signed'(rq.value) == signed'(shadow_words[mid])) begin
            r.status = STAT_OK;
            r.position = 4'(mid);
            break;
          end
          if (signed'(rq.value) < signed'(shadow_words[mid])) hi = mid - 1;
          else lo = mid + 1;
        end
      end
      FN_MAX, FN_MIN: begin
        if (shadow_fill == 0) r.status = STAT_EMPTY;
        else begin
          best = shadow_words[0];
          for (int i = 1; i < shadow_fill; i++) begin
            if (rq.func == FN_MAX ? (signed'(shadow_words[i]) > best)
                                  : (signed'(shadow_words[i]) < best))
              best = shadow_words[i];
          end
          r.data = 36'(best);
        end
      end
      FN_SUM: begin
        for (int i = 0; i < shadow_fill; i++)
          r.data = r.data + 36'(signed'(shadow_words[i]));
      end
      default: ;
    endcase
    r.count = shadow_fill;
    return r;
  endfunction

  task automatic send_request(input request_t rq, input bit fixed, input reply_t rsp);
    int gap;
    reply_t r;
    gap = walking ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, rq.value, rq.index};
    s_axis_tuser  <= rq.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_reply(rq);
    if (fixed && r != rsp) begin
      $error("table row func %0d: expected status %0d data %h count %0d, got %0d %h %0d",
             rq.func, rsp.status, rsp.data, rsp.count, r.status, r.data, r.count);
      error_count++;
    end
    pending_replies.push_back(r);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_cap = cap;
  endtask

  function automatic request_t make_req(input logic [3:0] f, input logic [4:0] i,
                                        input logic [31:0] v);
    request_t rq;
    rq.func = f;
    rq.index = i;
    rq.value = v;
    return rq;
  endfunction

  function automatic reply_t make_rsp(input logic [2:0] s, input logic [35:0] d,
                                      input logic [4:0] c);
    reply_t r;
    r.status = s;
    r.position = '0;
    r.data = d;
    r.count = c;
    return r;
  endfunction

  task automatic add_row(input request_t rq, input bit fixed, input reply_t rsp);
    vector_t v;
    v.req = rq;
    v.fixed = fixed;
    v.rsp = rsp;
    vectors.push_back(v);
  endtask

  function automatic request_t random_req();
    request_t rq;
    int pick;
    pick = $urandom_range(0, 99);
    rq.value = $urandom();
    rq.index = (shadow_fill > 0 && pick < 80) ? 5'($urandom_range(0, shadow_fill))
                                              : 5'($urandom_range(0, 31));
    if (shadow_fill > 0 && $urandom_range(0, 2) != 0)
      rq.value = shadow_words[$urandom_range(0, shadow_fill - 1)];
    if (pick < 25) rq.func = ($urandom_range(0, 1) != 0) ? FN_APPEND : FN_INSERT;
    else if (pick < 35) rq.func = FN_DELETE;
    else if (pick < 97) rq.func = 4'($urandom_range(0, 11));
    else rq.func = 4'($urandom_range(12, 15));
    return rq;
  endfunction

  initial begin : stimulus
    request_t rq;
    reply_t   none;
    none = make_rsp(STAT_OK, '0, '0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    shadow_fill = '0;
    shadow_cap = 5'd16;
    for (int i = 0; i < NUM_SLOTS; i++) shadow_words[i] = '0;

    add_row(make_req(FN_MAX, 5'd0, '0), 1, make_rsp(STAT_EMPTY, '0, 5'd0));
    add_row(make_req(FN_MIN, 5'd0, '0), 1, make_rsp(STAT_EMPTY, '0, 5'd0));
    add_row(make_req(FN_SUM, 5'd0, '0), 1, make_rsp(STAT_OK, '0, 5'd0));
    add_row(make_req(FN_GET, 5'd0, '0), 1, make_rsp(STAT_RANGE, '0, 5'd0));
    add_row(make_req(FN_DELETE, 5'd0, '0), 1, make_rsp(STAT_RANGE, '0, 5'd0));
    add_row(make_req(FN_SEARCH, 5'd0, '0), 1, make_rsp(STAT_MISS, '0, 5'd0));
    add_row(make_req(FN_BSEARCH, 5'd0, '0), 1, make_rsp(STAT_MISS, '0, 5'd0));
    add_row(make_req(FN_INSERT, 5'd1, '0), 1, make_rsp(STAT_RANGE, '0, 5'd0));
    add_row(make_req(FN_APPEND, 5'd31, 32'h8000_0000), 1, make_rsp(STAT_OK, '0, 5'd1));
    add_row(make_req(FN_APPEND, 5'd0, 32'h7FFF_FFFF), 1, make_rsp(STAT_OK, '0, 5'd2));
    add_row(make_req(FN_INSERT, 5'd0, 32'hFFFF_FFFF), 0, none);
    add_row(make_req(FN_INSERT, 5'd3, 32'd5), 0, none);
    add_row(make_req(FN_MAX, 5'd0, '0), 0, none);
    add_row(make_req(FN_MIN, 5'd0, '0), 0, none);
    add_row(make_req(FN_SUM, 5'd0, '0), 0, none);
    add_row(make_req(FN_TRANSPOSE, 5'd0, 32'hFFFF_FFFF), 0, none);
    add_row(make_req(FN_TRANSPOSE, 5'd0, 32'd5), 0, none);
    add_row(make_req(FN_TO_HEAD, 5'd0, 32'h7FFF_FFFF), 0, none);
    add_row(make_req(FN_SET, 5'd1, 32'h1234_5678), 0, none);
    add_row(make_req(FN_GET, 5'd1, '0), 0, none);
    add_row(make_req(FN_DELETE, 5'd3, '0), 0, none);
    add_row(make_req(FN_BSEARCH, 5'd0, 32'h1234_5678), 0, none);
    add_row(make_req(4'd15, 5'd31, 32'hFFFF_FFFF), 0, none);
    add_row(make_req(FN_INSERT, 5'd5, '0), 1, make_rsp(STAT_RANGE, '0, 5'd3));
    foreach (vectors[i]) send_request(vectors[i].req, vectors[i].fixed, vectors[i].rsp);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i)
        150:  write_capacity(5'd0);
        300:  write_capacity(5'd31);
        500:  write_capacity(5'd3);
        700:  write_capacity(5'd16);
        900:  write_capacity(5'd9);
        1100: write_capacity(5'd16);
        default: ;
      endcase
      walking = (i >= 400 && i < 440);
      if (i == 420) hold_off = 1'b1;
      if (i % 200 == 100) begin
        // sorted run for binary search
        while (shadow_fill > 0) send_request(make_req(FN_DELETE, 5'd0, '0), 0, none);
        rq.value = 32'h8000_0000 + $urandom_range(0, 1000);
        for (int k = 0; k < room_limit(); k++) begin
          send_request(make_req(FN_APPEND, 5'd0, rq.value), 0, none);
          rq.value = rq.value + $urandom_range(0, 400000000);
          if (signed'(rq.value) < 0 && k > 8) rq.value = 32'h7FFF_FFFF;
        end
        for (int k = 0; k < 12; k++) begin
          rq = make_req(FN_BSEARCH, '0, $urandom_range(0, 1) ? 32'($urandom())
                        : shadow_words[$urandom_range(0, shadow_fill > 0 ? shadow_fill - 1 : 0)]);
          send_request(rq, 0, none);
        end
      end
      send_request(random_req(), 0, none);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin : receiver
    int gap;
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if (walking) gap = 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result transfer");
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[3:0] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, m_axis_tdata[3:0]);
          error_count++;
        end
        if (m_axis_tdata[39:4] !== want.data) begin
          $error("data: expected %h, got %h", want.data, m_axis_tdata[39:4]);
          error_count++;
        end
        if (m_axis_tdata[44:40] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, m_axis_tdata[44:40]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
